/* rtl/assert_macros.svh */
// Assertion macros shared by the inverse transform RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/itx_pkg.sv */
// Shared types, widths and the 8-point weight matrix of the 8x8 inverse transform.
// No dependencies.
package itx_pkg;

   localparam int N      = 8;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = 2 * IDX_W;
   localparam int COEF_W = 12;
   localparam int TMP_W  = 16;
   localparam int RES_W  = 11;
   localparam int DATA_W = 16;
   localparam int WT_W   = 6;
   localparam int ACC1_W = 20;
   localparam int ACC2_W = 24;

   localparam int BIAS1  = 4;
   localparam int SHIFT1 = 3;
   localparam int BIAS2  = 64;
   localparam int SHIFT2 = 7;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [TMP_W-1:0]  tmp_type;
   typedef tmp_type [N-1:0]          tmp_row_type;
   typedef logic signed [RES_W-1:0]  res_type;
   typedef logic signed [WT_W-1:0]   wt_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   localparam res_type RES_MAX = 11'sd1023;
   localparam res_type RES_MIN = -11'sd1024;

   // output i (row) times input k (column): even part 12/16/6, odd part 16/15/9/4
   localparam wt_type WMAT [N][N] = '{
      '{12,  16,  16,  15,  12,   9,   6,   4},
      '{12,  15,   6,  -4, -12, -16, -16,  -9},
      '{12,   9,  -6, -16, -12,   4,  16,  15},
      '{12,   4, -16,  -9,  12,  15,  -6, -16},
      '{12,  -4, -16,   9,  12, -15,  -6,  16},
      '{12,  -9,  -6,  16, -12,  -4,  16, -15},
      '{12, -15,   6,   4, -12,  16, -16,   9},
      '{12, -16,  16, -15,  12,  -9,   6,  -4}
   };

   // write port of the intermediate row memory
   typedef struct packed {
      logic        en;
      idx_type     addr;
      tmp_row_type data;
   } tmp_wr_type;

endpackage

/* rtl/itx_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module itx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/itx_front.sv */
// Coefficient load and first (column) pass: coefficient RAM plus eight MAC lanes.
// Depends on itx_pkg, itx_ram and assert_macros.svh.
`include "assert_macros.svh"

module itx_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [itx_pkg::DATA_W-1:0]  req_tdata,   // [11:0] coefficient
   input  logic                        busy_i,
   output itx_pkg::tmp_wr_type         tmp_wr,
   output logic                        pass_done
);
   import itx_pkg::*;

   typedef enum logic [2:0] {
      F_LOAD = 3'b001,
      F_WAIT = 3'b010,
      F_PASS = 3'b100
   } fstate_type;

   localparam cnt_type LAST_CNT = '1;
   localparam idx_type LAST_IDX = '1;

   fstate_type state_ff, state_in;
   cnt_type    load_cnt_ff, load_cnt_in;
   cnt_type    rd_cnt_ff, rd_cnt_in;
   logic       issue_ff, issue_in;
   logic       d_vld_ff, d_vld_in;
   idx_type    d_c_ff, d_c_in;
   idx_type    d_k_ff, d_k_in;
   logic signed [ACC1_W-1:0] acc_ff [N];
   logic signed [ACC1_W-1:0] acc_in [N];
   logic signed [ACC1_W-1:0] sum [N];

   logic              req_accept;
   logic              col_done;
   cnt_type           coef_rd_addr;
   logic [COEF_W-1:0] coef_rd_data;
   coef_type          x;

   itx_ram #(.WIDTH(COEF_W), .DEPTH(N * N)) u_coef_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_cnt_ff),
      .wr_data (req_tdata[COEF_W-1:0]),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   assign req_tready   = (state_ff == F_LOAD);
   assign req_accept   = req_tvalid && req_tready;
   // rd_cnt is {column, k}; the coefficient sits at 8k + column
   assign coef_rd_addr = {rd_cnt_ff[IDX_W-1:0], rd_cnt_ff[CNT_W-1:IDX_W]};
   assign x            = coef_type'(coef_rd_data);
   assign col_done     = d_vld_ff && (d_k_ff == LAST_IDX);
   assign pass_done    = col_done && (d_c_ff == LAST_IDX);

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      rd_cnt_in   = rd_cnt_ff;
      issue_in    = issue_ff;
      unique case (state_ff)
         F_LOAD: begin
            if (req_accept) begin
               load_cnt_in = load_cnt_ff + 1'b1;
               if (load_cnt_ff == LAST_CNT) state_in = F_WAIT;
            end
         end
         F_WAIT: begin
            // intermediate rows still in use by the second pass
            if (!busy_i) begin
               state_in  = F_PASS;
               issue_in  = 1'b1;
               rd_cnt_in = '0;
            end
         end
         F_PASS: begin
            if (issue_ff) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
               if (rd_cnt_ff == LAST_CNT) issue_in = 1'b0;
            end
            if (pass_done) state_in = F_LOAD;
         end
         default: state_in = F_LOAD;
      endcase
   end

   assign d_vld_in = issue_ff;
   assign d_c_in   = rd_cnt_ff[CNT_W-1:IDX_W];
   assign d_k_in   = rd_cnt_ff[IDX_W-1:0];

   always_comb begin
      tmp_wr.en   = col_done;
      tmp_wr.addr = d_c_ff;
      for (int i = 0; i < N; i++) begin
         sum[i] = ((d_k_ff == '0) ? ACC1_W'(BIAS1) : acc_ff[i])
                + ACC1_W'(WMAT[i][d_k_ff]) * ACC1_W'(x);
         acc_in[i] = d_vld_ff ? sum[i] : acc_ff[i];
         tmp_wr.data[i] = TMP_W'(sum[i] >>> SHIFT1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_LOAD;
         load_cnt_ff <= '0;
         issue_ff    <= 1'b0;
         d_vld_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         issue_ff    <= issue_in;
         d_vld_ff    <= d_vld_in;
      end
      rd_cnt_ff <= rd_cnt_in;
      d_c_ff    <= d_c_in;
      d_k_ff    <= d_k_in;
      for (int i = 0; i < N; i++) begin
         acc_ff[i] <= acc_in[i];
      end
   end

   `ASSERT_IMPLY(a_pass_with_idle_back, clock, reset, state_ff == F_PASS, !busy_i, "first pass overlaps second pass")
   `ASSERT_NEXT(a_block_wraps, clock, reset, req_accept && load_cnt_ff == LAST_CNT, state_ff == F_WAIT && load_cnt_ff == '0, "load count did not wrap at block end")
   `ASSERT_NEXT(a_pass_ends_in_load, clock, reset, pass_done, state_ff == F_LOAD, "first pass did not return to load")

endmodule

/* rtl/itx_back.sv */
// Second (row) pass over the intermediate rows, saturation and the residual output buffer.
// Depends on itx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itx_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_i,
   output logic                        busy_o,
   output itx_pkg::idx_type            tmp_rd_addr,
   input  itx_pkg::tmp_row_type        tmp_rd_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [itx_pkg::DATA_W-1:0]  rsp_tdata,   // [10:0] residual
   output logic                        rsp_tlast    // last_sample
);
   import itx_pkg::*;

   localparam cnt_type LAST_CNT = '1;
   localparam idx_type LAST_IDX = '1;

   logic    busy_ff, busy_in;
   logic    issue_ff, issue_in;
   cnt_type rd_cnt_ff, rd_cnt_in;
   logic    d_vld_ff, d_vld_in;
   idx_type d_row_ff, d_row_in;
   idx_type d_k_ff, d_k_in;
   logic    buf_vld_ff, buf_vld_in;
   idx_type buf_row_ff, buf_row_in;
   idx_type emit_ff, emit_in;
   logic signed [ACC2_W-1:0] acc_ff [N];
   logic signed [ACC2_W-1:0] acc_in [N];
   logic signed [ACC2_W-1:0] sum [N];
   logic signed [ACC2_W-1:0] shifted [N];
   res_type buf_ff [N];
   res_type sat [N];

   logic    rsp_accept;
   logic    buf_last;
   logic    can_issue;
   logic    row_done;
   idx_type rd_k;

   assign rd_k        = rd_cnt_ff[IDX_W-1:0];
   assign buf_last    = (emit_ff == LAST_IDX);
   assign rsp_accept  = buf_vld_ff && rsp_tready;
   // the row's last read may go only if the buffer is free when its data lands
   assign can_issue   = issue_ff &&
                        (rd_k != LAST_IDX || !buf_vld_ff || (buf_last && rsp_tready));
   assign tmp_rd_addr = rd_k;
   assign row_done    = d_vld_ff && (d_k_ff == LAST_IDX);

   assign d_vld_in = can_issue;
   assign d_row_in = rd_cnt_ff[CNT_W-1:IDX_W];
   assign d_k_in   = rd_k;

   always_comb begin
      busy_in   = busy_ff;
      issue_in  = issue_ff;
      rd_cnt_in = rd_cnt_ff;
      if (start_i) begin
         busy_in   = 1'b1;
         issue_in  = 1'b1;
         rd_cnt_in = '0;
      end else begin
         if (can_issue) begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == LAST_CNT) issue_in = 1'b0;
         end
         if (rsp_accept && buf_last && buf_row_ff == LAST_IDX) busy_in = 1'b0;
      end
   end

   always_comb begin
      for (int c = 0; c < N; c++) begin
         // rows 4..7 carry the extra +1 ahead of the shift
         sum[c] = ((d_k_ff == '0) ? ACC2_W'(BIAS2 + int'(d_row_ff[IDX_W-1])) : acc_ff[c])
                + ACC2_W'(WMAT[d_row_ff][d_k_ff]) * ACC2_W'(tmp_rd_data[c]);
         acc_in[c]  = d_vld_ff ? sum[c] : acc_ff[c];
         shifted[c] = sum[c] >>> SHIFT2;
         if (shifted[c] > RES_MAX) begin
            sat[c] = RES_MAX;
         end else if (shifted[c] < RES_MIN) begin
            sat[c] = RES_MIN;
         end else begin
            sat[c] = RES_W'(shifted[c]);
         end
      end
   end

   always_comb begin
      buf_vld_in = buf_vld_ff;
      buf_row_in = buf_row_ff;
      emit_in    = emit_ff;
      priority if (row_done) begin
         buf_vld_in = 1'b1;
         buf_row_in = d_row_ff;
         emit_in    = '0;
      end else if (rsp_accept) begin
         emit_in = emit_ff + 1'b1;
         if (buf_last) buf_vld_in = 1'b0;
      end else begin
         buf_vld_in = buf_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         issue_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         buf_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         issue_ff   <= issue_in;
         d_vld_ff   <= d_vld_in;
         buf_vld_ff <= buf_vld_in;
      end
      rd_cnt_ff  <= rd_cnt_in;
      d_row_ff   <= d_row_in;
      d_k_ff     <= d_k_in;
      buf_row_ff <= buf_row_in;
      emit_ff    <= emit_in;
      for (int c = 0; c < N; c++) begin
         acc_ff[c] <= acc_in[c];
         if (row_done) buf_ff[c] <= sat[c];
      end
   end

   assign busy_o     = busy_ff;
   assign rsp_tvalid = buf_vld_ff;
   assign rsp_tdata  = {{(DATA_W - RES_W){1'b0}}, buf_ff[emit_ff]};
   assign rsp_tlast  = buf_vld_ff && buf_last && (buf_row_ff == LAST_IDX);

   `ASSERT_IMPLY(a_buf_free_on_load, clock, reset, row_done, !buf_vld_ff, "row result overwrites unsent beats")
   `ASSERT_IMPLY(a_last_while_busy, clock, reset, rsp_tvalid && rsp_tlast, busy_ff, "last beat outside a block")
   `ASSERT_IMPLY(a_start_when_idle, clock, reset, start_i, !busy_ff && !issue_ff, "second pass restarted while busy")

endmodule

/* rtl/inverse_transform_8x8.sv */
// 8x8 integer inverse transform: 64 coefficients in, 64 saturated residuals out, array order.
// After the 64th coefficient beat, and once the row pass is idle, the first pass runs over all
// eight columns; the row pass then computes one row at a time into the output buffer, and each
// row's eight residuals go out while the next row is computed, held while the output stalls.
// Blocks: a first pass waits for the previous row pass to drain; the next 64-beat load
// overlaps that row pass.
// Reset clears control only; the memories hold stale data that is always written before read.
module inverse_transform_8x8 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [itx_pkg::DATA_W-1:0]  req_tdata,   // [11:0] coefficient
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [itx_pkg::DATA_W-1:0]  rsp_tdata,   // [10:0] residual
   output logic                        rsp_tlast    // last_sample
);
   import itx_pkg::*;

   tmp_wr_type  tmp_wr;
   idx_type     tmp_rd_addr;
   tmp_row_type tmp_rd_data;
   logic        pass_done;
   logic        back_busy;

   itx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .busy_i     (back_busy),
      .tmp_wr     (tmp_wr),
      .pass_done  (pass_done)
   );

   // one word per first-pass column: its eight outputs
   itx_ram #(.WIDTH(N * TMP_W), .DEPTH(N)) u_tmp_ram (
      .clock   (clock),
      .wr_en   (tmp_wr.en),
      .wr_addr (tmp_wr.addr),
      .wr_data (tmp_wr.data),
      .rd_addr (tmp_rd_addr),
      .rd_data (tmp_rd_data)
   );

   itx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .start_i     (pass_done),
      .busy_o      (back_busy),
      .tmp_rd_addr (tmp_rd_addr),
      .tmp_rd_data (tmp_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* tb/sv/tb_inverse_transform_8x8.sv */
// Self-checking testbench for inverse_transform_8x8: streams 8x8 coefficient blocks and
// checks every residual beat against an in-bench prediction of the 2D integer transform.
// Depends on itx_pkg and the inverse_transform_8x8 RTL.
`timescale 1ns / 100ps

module tb_inverse_transform_8x8;
   import itx_pkg::*;

   localparam int BLOCK     = 64;
   localparam int CYCLE_MAX = 60000;
   localparam int DRAIN     = 300;

   typedef struct packed {
      res_type residual;
      logic    last_sample;
   } residual_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   coef_type          coef_pending[$];
   residual_beat_type residual_fifo[$];
   residual_beat_type want;

   // prediction state
   int coef_mem[BLOCK];
   int mid_mem[BLOCK];
   int res_mem[BLOCK];
   int lane_in[8];
   int lane_out[8];
   int load_cnt = 0;

   int coef_accepted   = 0;
   int residual_seen   = 0;
   int blocks_done     = 0;
   int saturated_count = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   inverse_transform_8x8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // 8-point butterfly over lane_in into lane_out; >>> on int is a floor shift
   task automatic butterfly8(input int bias, input int extra, input int sh);
      int e0, e1, e2, e3, a0, a1, a2, a3, d0, d1, d2, d3;
      e0 = 12 * (lane_in[0] + lane_in[4]) + bias;
      e1 = 12 * (lane_in[0] - lane_in[4]) + bias;
      e2 = 16 * lane_in[2] + 6 * lane_in[6];
      e3 = 6 * lane_in[2] - 16 * lane_in[6];
      a0 = e0 + e2;
      a1 = e1 + e3;
      a2 = e1 - e3;
      a3 = e0 - e2;
      d0 = 16 * lane_in[1] + 15 * lane_in[3] + 9 * lane_in[5] + 4 * lane_in[7];
      d1 = 15 * lane_in[1] - 4 * lane_in[3] - 16 * lane_in[5] - 9 * lane_in[7];
      d2 = 9 * lane_in[1] - 16 * lane_in[3] + 4 * lane_in[5] + 15 * lane_in[7];
      d3 = 4 * lane_in[1] - 9 * lane_in[3] + 15 * lane_in[5] - 16 * lane_in[7];
      lane_out[0] = (a0 + d0) >>> sh;
      lane_out[1] = (a1 + d1) >>> sh;
      lane_out[2] = (a2 + d2) >>> sh;
      lane_out[3] = (a3 + d3) >>> sh;
      lane_out[4] = (a3 - d3 + extra) >>> sh;
      lane_out[5] = (a2 - d2 + extra) >>> sh;
      lane_out[6] = (a1 - d1 + extra) >>> sh;
      lane_out[7] = (a0 - d0 + extra) >>> sh;
   endtask

   // store one coefficient; on the 64th, transform the block and queue its residuals
   task automatic load_coefficient(input coef_type c);
      int col, k, i, n, v;
      residual_beat_type beat;
      coef_mem[load_cnt] = c;
      load_cnt++;
      if (load_cnt == BLOCK) begin
         load_cnt = 0;
         blocks_done++;
         for (col = 0; col < 8; col++) begin
            for (k = 0; k < 8; k++) lane_in[k] = coef_mem[col + 8 * k];
            butterfly8(BIAS1, 0, SHIFT1);
            for (i = 0; i < 8; i++) mid_mem[col * 8 + i] = lane_out[i];
         end
         for (col = 0; col < 8; col++) begin
            for (k = 0; k < 8; k++) lane_in[k] = mid_mem[col + 8 * k];
            butterfly8(BIAS2, 1, SHIFT2);
            for (i = 0; i < 8; i++) begin
               v = lane_out[i];
               if (v > int'(RES_MAX) || v < int'(RES_MIN)) saturated_count++;
               if (v > int'(RES_MAX)) v = int'(RES_MAX);
               if (v < int'(RES_MIN)) v = int'(RES_MIN);
               res_mem[i * 8 + col] = v;
            end
         end
         for (n = 0; n < BLOCK; n++) begin
            beat.residual    = res_type'(res_mem[n]);
            beat.last_sample = (n == BLOCK - 1);
            residual_fifo.push_back(beat);
         end
      end
   endtask

   // idle percentage per traffic phase; phases rotate every 40 beats on each side
   function automatic int idle_pct(input int beats, input bit rx_side);
      case ((beats / 40) % 4)
         0: return 0;
         1: return rx_side ? 0 : 60;
         2: return rx_side ? 60 : 0;
         default: return 19;
      endcase
   endfunction

   // coefficient driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            load_coefficient(coef_type'(req_tdata[COEF_W-1:0]));
            coef_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (coef_pending.size() > 0 && $urandom_range(99) >= idle_pct(coef_accepted, 1'b0))
            begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(DATA_W-COEF_W){1'b0}}, coef_pending.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // residual monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (residual_fifo.size() == 0) begin
               $display("%0t: unexpected residual beat: expected none, got data=%h last=%b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = residual_fifo.pop_front();
               if (rsp_tdata[RES_W-1:0] !== want.residual) begin
                  $display("%0t: residual beat %0d: expected %0d, got %0d", $time,
                           residual_seen, want.residual, $signed(rsp_tdata[RES_W-1:0]));
                  error_count++;
               end
               if (rsp_tdata[DATA_W-1:RES_W] !== '0) begin
                  $display("%0t: residual beat %0d pad bits: expected 0, got %h", $time,
                           residual_seen, rsp_tdata[DATA_W-1:RES_W]);
                  error_count++;
               end
               if (rsp_tlast !== want.last_sample) begin
                  $display("%0t: residual beat %0d tlast: expected %b, got %b", $time,
                           residual_seen, want.last_sample, rsp_tlast);
                  error_count++;
               end
            end
            residual_seen++;
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct(residual_seen, 1'b1));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_MAX) begin
         $display("%0t: timeout after %0d cycles, %0d residuals still expected", $time,
                  cycle_count, residual_fifo.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int n, tail;
      coef_type c;

      // directed: checkerboard of extremes (worst-case high frequency, saturates both ways)
      for (n = 0; n < BLOCK; n++) begin
         c = (((n / 8) + (n % 8)) % 2 == 1) ? coef_type'(-2048) : coef_type'(2047);
         coef_pending.push_back(c);
      end
      // random block: each coefficient full range, small or zero
      for (n = 0; n < BLOCK; n++) begin
         case ($urandom_range(2))
            0: c = coef_type'($urandom_range(4095));
            1: c = coef_type'(int'($urandom_range(64)) - 32);
            default: c = '0;
         endcase
         coef_pending.push_back(c);
      end
      // trailing partial block: must produce nothing
      tail = $urandom_range(46, 38);
      for (n = 0; n < tail; n++) coef_pending.push_back(coef_type'($urandom_range(4095)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (coef_pending.size() != 0 || req_tvalid) @(posedge clock);
      while (residual_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Covered %0d coefficient beats (%0d full blocks plus a partial one).",
               coef_accepted, blocks_done);
      $display("Checked %0d residual beats, %0d of them clamped at the output range.",
               residual_seen, saturated_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/itx_pkg.sv
rtl/itx_ram.sv
rtl/itx_front.sv
rtl/itx_back.sv
rtl/inverse_transform_8x8.sv
tb/sv/tb_inverse_transform_8x8.sv
